// ----- src/clri_pkg.sv -----
// Shared types and constants for the circular list block.
// Field widths, operation codes and the cell select struct live here.
// No dependencies.
`default_nettype none

package clri_pkg;

  localparam int unsigned FUNC_W       = 2;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef struct packed {
    logic load_val;
    logic take_left;
    logic take_right;
    logic take_head;
  } cell_sel_t;

endpackage

`default_nettype wire

// ----- src/clri_in_if.sv -----
// Input channel of the circular list block: valid, ready and one operation.
// Depends on clri_pkg for the field widths.
`default_nettype none

interface clri_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [clri_pkg::FUNC_W-1:0]      func;
  logic signed [clri_pkg::POS_W-1:0]       position;
  logic signed [clri_pkg::VAL_W-1:0]       value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

`default_nettype wire

// ----- src/clri_out_if.sv -----
// Output channel of the circular list block: valid, ready and one result.
// Depends on clri_pkg for the field widths.
`default_nettype none

interface clri_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    status;
  logic signed [clri_pkg::VAL_W-1:0]       removed_value;
  logic signed [clri_pkg::VAL_W-1:0]       front_value;
  logic signed [clri_pkg::VAL_W-1:0]       back_value;
  logic        [clri_pkg::COUNT_W-1:0]     count;

  modport source (output valid, output status, output removed_value, output front_value,
                  output back_value, output count, input ready);
  modport sink   (input valid, input status, input removed_value, input front_value,
                  input back_value, input count, output ready);
endinterface

`default_nettype wire

// ----- src/clri_cell.sv -----
// One storage cell of the list chain: holds one entry in logical order.
// Depends on clri_pkg for the select struct and the value width.
`default_nettype none

module clri_cell (
  input  wire                               clk_i,
  input  wire clri_pkg::cell_sel_t          sel_i,
  input  wire logic [clri_pkg::VAL_W-1:0]   value_i,
  input  wire logic [clri_pkg::VAL_W-1:0]   left_i,
  input  wire logic [clri_pkg::VAL_W-1:0]   right_i,
  input  wire logic [clri_pkg::VAL_W-1:0]   head_i,
  output logic      [clri_pkg::VAL_W-1:0]   data_o,
  output logic      [clri_pkg::VAL_W-1:0]   next_o
);

  logic [clri_pkg::VAL_W-1:0] data_q;
  logic [clri_pkg::VAL_W-1:0] data_d;

  always_comb begin
    priority if (sel_i.load_val) begin
      data_d = value_i;
    end else if (sel_i.take_left) begin
      data_d = left_i;
    end else if (sel_i.take_right) begin
      data_d = right_i;
    end else if (sel_i.take_head) begin
      data_d = head_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign next_o = data_d;

endmodule

`default_nettype wire

// ----- src/circular_list_insert_remove_rotate_top.sv -----
// Circular ordered list of signed 32-bit values with insert, remove and rotate.
// Built from a chain of clri_cell instances; uses clri_pkg, clri_in_if and clri_out_if.
//
// Usage:
//   in_i carries one operation per transaction: func (add, remove, advance),
//   position (-1 selects the tail) and value. out_o returns one result per
//   transaction: status, removed value, front value, back value and count.
//   Entries sit in logical order in a row of cells, cell 0 being the front.
//   Every operation that is not rejected updates the cells in parallel: an insert shifts
//   the cells behind the position one place back, a remove pulls them forward,
//   and an advance pulls every live cell forward and loads the old front into
//   the last live cell.
//   An accepted transaction's result is registered in the output register in the
//   next cycle; throughput is one transaction per cycle while results are taken.
//   The input is ready whenever the output register is empty or being taken
//   in the same cycle; a stalled receiver holds the result and the input.
//   Reset empties the list and the output register; cell contents are not
//   cleared and are never read before being written.
`default_nettype none

module circular_list_insert_remove_rotate_top #(
  parameter int unsigned CAPACITY = clri_pkg::CAPACITY_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  clri_in_if.sink    in_i,
  clri_out_if.source out_o
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned IW    = $clog2(CAPACITY);
  localparam int unsigned PW    = clri_pkg::POS_W - 1;
  localparam int unsigned CMP_W = (CW > PW) ? CW : PW;
  localparam int unsigned VW    = clri_pkg::VAL_W;

  logic [CW-1:0] count_q, count_d;
  logic          fire;
  logic          ok;
  logic          pos_tail, pos_nonneg;
  logic [CMP_W-1:0] pos_u, n_ext, n_m1, p_add, p_rem;
  logic          add_ok, rem_ok;
  logic          is_add, is_rem, is_adv;

  logic [VW-1:0] data_w [CAPACITY];
  logic [VW-1:0] next_w [CAPACITY];
  clri_pkg::cell_sel_t sel_w [CAPACITY];

  logic          out_valid_q;
  logic          status_q;
  logic [VW-1:0] removed_q, front_q, back_q;
  logic [clri_pkg::COUNT_W-1:0] count_out_q;
  logic [VW-1:0] removed_d, front_d, back_d;
  logic [IW-1:0] back_idx, rem_idx;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  assign pos_tail   = (in_i.position == -6'sd1);
  assign pos_nonneg = !in_i.position[clri_pkg::POS_W-1];
  assign pos_u      = CMP_W'(in_i.position[PW-1:0]);
  assign n_ext      = CMP_W'(count_q);
  assign n_m1       = n_ext - CMP_W'(1);

  assign add_ok = (pos_tail || (pos_nonneg && pos_u <= n_ext)) &&
                  (n_ext != CMP_W'(CAPACITY));
  assign rem_ok = (n_ext != '0) && (pos_tail || (pos_nonneg && pos_u < n_ext));
  assign p_add  = pos_tail ? n_ext : pos_u;
  assign p_rem  = pos_tail ? n_m1  : pos_u;

  assign is_add = fire && (in_i.func == clri_pkg::FUNC_ADD) && add_ok;
  assign is_rem = fire && (in_i.func == clri_pkg::FUNC_REMOVE) && rem_ok;
  assign is_adv = fire && (in_i.func == clri_pkg::FUNC_ADVANCE) && (n_ext != '0);

  always_comb begin
    unique case (in_i.func)
      clri_pkg::FUNC_ADD: begin
        ok      = add_ok;
        count_d = add_ok ? count_q + CW'(1) : count_q;
      end
      clri_pkg::FUNC_REMOVE: begin
        ok      = rem_ok;
        count_d = rem_ok ? count_q - CW'(1) : count_q;
      end
      clri_pkg::FUNC_ADVANCE: begin
        ok      = 1'b1;
        count_d = count_q;
      end
      default: begin
        ok      = 1'b0;
        count_d = count_q;
      end
    endcase
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);
    logic [VW-1:0] left, right;

    if (gi == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = data_w[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right = data_w[gi];
    end else begin : g_inner
      assign right = data_w[gi+1];
    end

    assign sel_w[gi].load_val   = is_add && (IDX == p_add);
    assign sel_w[gi].take_left  = is_add && (IDX > p_add) && (IDX <= n_ext);
    assign sel_w[gi].take_right = (is_rem && (IDX >= p_rem)) || (is_adv && (IDX < n_m1));
    assign sel_w[gi].take_head  = is_adv && (IDX == n_m1);

    clri_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel_w[gi]),
      .value_i (in_i.value),
      .left_i  (left),
      .right_i (right),
      .head_i  (data_w[0]),
      .data_o  (data_w[gi]),
      .next_o  (next_w[gi])
    );
  end

  assign back_idx  = IW'(count_d - CW'(1));
  assign rem_idx   = IW'(p_rem);
  assign removed_d = ((in_i.func == clri_pkg::FUNC_REMOVE) && rem_ok) ? data_w[rem_idx] : '0;
  assign front_d   = (count_d != '0) ? next_w[0] : '0;
  assign back_d    = (count_d != '0) ? next_w[back_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q    <= ok ? clri_pkg::STATUS_DONE : clri_pkg::STATUS_REJECTED;
      removed_q   <= removed_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_out_q <= clri_pkg::COUNT_W'(count_d);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.removed_value = removed_q;
  assign out_o.front_value   = front_q;
  assign out_o.back_value    = back_q;
  assign out_o.count         = count_out_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("Input ready while a result is stalled.");

  a_reject_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !ok) |=> $stable(count_q))
    else $error("Rejected transaction changed the entry count.");

  a_result_follows_fire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_o.valid)
    else $error("Accepted transaction produced no result.");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for circular_list_insert_remove_rotate_top: add, remove and rotate
// operations go in over a valid/ready channel and each result is checked against a predicted list.
// Depends on clri_pkg, clri_in_if, clri_out_if and the block's RTL.

module tb_top;

  localparam int unsigned CAPACITY    = clri_pkg::CAPACITY_DEF;
  localparam logic [clri_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_OPS  = 850;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic        [clri_pkg::FUNC_W-1:0] func;
    logic signed [clri_pkg::POS_W-1:0]  position;
    logic signed [clri_pkg::VAL_W-1:0]  value;
    int unsigned                        phase;
  } list_op_t;

  typedef struct {
    logic                                status;
    logic signed [clri_pkg::VAL_W-1:0]   removed_value;
    logic signed [clri_pkg::VAL_W-1:0]   front_value;
    logic signed [clri_pkg::VAL_W-1:0]   back_value;
    logic        [clri_pkg::COUNT_W-1:0] count;
  } list_result_t;

  logic clk_i;
  logic rst_ni;

  clri_in_if  op_if ();
  clri_out_if res_if ();

  circular_list_insert_remove_rotate_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if)
  );

  list_op_t                          queued_ops[$];
  list_result_t                      awaited_results[$];
  logic signed [clri_pkg::VAL_W-1:0] list_values[$];

  int unsigned send_idle_pct[3] = '{27, 63, 0};
  int unsigned recv_idle_pct[3] = '{63, 27, 0};
  int unsigned idle_phase;
  int unsigned hold_left;
  logic        hold_done;

  int          gen_count;
  logic        growing;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned ops_accepted;
  int unsigned ops_rejected;
  int unsigned full_seen;
  int unsigned results_checked;

  always #5 clk_i = ~clk_i;

  function automatic list_result_t apply_list_op(
      input logic [clri_pkg::FUNC_W-1:0] func,
      input logic signed [clri_pkg::POS_W-1:0] position,
      input logic signed [clri_pkg::VAL_W-1:0] value);
    list_result_t r;
    int           pos;
    int           n;
    int           slot;
    pos = position;
    n = list_values.size();
    r.status = clri_pkg::STATUS_DONE;
    r.removed_value = '0;
    r.front_value = '0;
    r.back_value = '0;
    unique case (func)
      clri_pkg::FUNC_ADD: begin
        if (pos < -1 || pos > n || n >= int'(CAPACITY)) begin
          r.status = clri_pkg::STATUS_REJECTED;
        end else begin
          slot = (pos == -1) ? n : pos;
          list_values.insert(slot, value);
        end
      end
      clri_pkg::FUNC_REMOVE: begin
        if (n == 0 || pos < -1 || pos >= n) begin
          r.status = clri_pkg::STATUS_REJECTED;
        end else begin
          slot = (pos == -1) ? n - 1 : pos;
          r.removed_value = list_values[slot];
          list_values.delete(slot);
        end
      end
      clri_pkg::FUNC_ADVANCE: begin
        if (n != 0) list_values.push_back(list_values.pop_front());
      end
      default: begin
        r.status = clri_pkg::STATUS_REJECTED;
      end
    endcase
    if (list_values.size() != 0) begin
      r.front_value = list_values[0];
      r.back_value = list_values[list_values.size() - 1];
    end
    r.count = clri_pkg::COUNT_W'(list_values.size());
    return r;
  endfunction

  task automatic queue_op(input logic [clri_pkg::FUNC_W-1:0] func, input int pos,
                          input logic signed [clri_pkg::VAL_W-1:0] val,
                          input int unsigned phase);
    list_op_t op;
    int       p;
    op.func = func;
    op.position = clri_pkg::POS_W'(pos);
    op.value = val;
    op.phase = phase;
    p = op.position;
    queued_ops.push_back(op);
    if (func == clri_pkg::FUNC_ADD && p >= -1 && p <= gen_count &&
        gen_count < int'(CAPACITY)) begin
      gen_count++;
    end else if (func == clri_pkg::FUNC_REMOVE && gen_count > 0 && p >= -1 &&
                 p < gen_count) begin
      gen_count--;
    end
  endtask

  task automatic queue_random_op(input int unsigned phase);
    logic        [clri_pkg::FUNC_W-1:0] func;
    int                                 pos;
    logic signed [clri_pkg::VAL_W-1:0]  val;
    int unsigned                        r;
    int                                 hi;
    r = $urandom_range(99);
    if (r < 3) func = FUNC_UNUSED;
    else if (r < 13) func = clri_pkg::FUNC_ADVANCE;
    else if ($urandom_range(99) < (growing ? 70 : 25)) func = clri_pkg::FUNC_ADD;
    else func = clri_pkg::FUNC_REMOVE;
    hi = (func == clri_pkg::FUNC_ADD) ? gen_count : gen_count - 1;
    r = $urandom_range(99);
    if (r < 15) pos = -1;
    else if (r < 80 && hi >= 0) pos = $urandom_range(hi, 0);
    else if (r < 90) pos = ($urandom_range(1) != 0) ? hi + 1 : -2;
    else pos = $urandom_range(63);
    case ($urandom_range(9))
      0: val = 32'h7FFF_FFFF;
      1: val = 32'h8000_0000;
      2: val = '0;
      3: val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    queue_op(func, pos, val, phase);
    if (gen_count == int'(CAPACITY)) growing = 1'b0;
    else if (gen_count == 0) growing = 1'b1;
    else if ($urandom_range(99) < 2) growing = !growing;
  endtask

  task automatic note_mismatch(input list_result_t want, input list_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (expected/actual): status %0d/%0d removed %0d/%0d front %0d/%0d",
               want.status, got.status, want.removed_value, got.removed_value,
               want.front_value, got.front_value);
      $display("  back %0d/%0d count %0d/%0d", want.back_value, got.back_value,
               want.count, got.count);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_op_t     op;
    list_result_t res;
    if (!rst_ni) begin
      op_if.valid <= 1'b0;
      op_if.func <= clri_pkg::FUNC_ADD;
      op_if.position <= '0;
      op_if.value <= '0;
      idle_phase <= 0;
    end else begin
      if (op_if.valid && op_if.ready) begin
        res = apply_list_op(op_if.func, op_if.position, op_if.value);
        awaited_results.push_back(res);
        ops_accepted++;
        if (res.status == clri_pkg::STATUS_REJECTED) ops_rejected++;
        if (res.count == CAPACITY) full_seen++;
      end
      if (!op_if.valid || op_if.ready) begin
        if (queued_ops.size() != 0 &&
            $urandom_range(99) >= send_idle_pct[queued_ops[0].phase]) begin
          op = queued_ops.pop_front();
          op_if.valid <= 1'b1;
          op_if.func <= op.func;
          op_if.position <= op.position;
          op_if.value <= op.value;
          idle_phase <= op.phase;
        end else begin
          op_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && idle_phase == 2) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    list_result_t got;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.status = res_if.status;
        got.removed_value = res_if.removed_value;
        got.front_value = res_if.front_value;
        got.back_value = res_if.back_value;
        got.count = res_if.count;
        results_checked++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result arrived with no transaction awaiting it.");
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.removed_value !== want.removed_value ||
              got.front_value !== want.front_value || got.back_value !== want.back_value ||
              got.count !== want.count) begin
            note_mismatch(want, got);
          end
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct[idle_phase]);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_cnt,
               awaited_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int p;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    op_if.valid = 1'b0;
    op_if.func = clri_pkg::FUNC_ADD;
    op_if.position = '0;
    op_if.value = '0;
    res_if.ready = 1'b0;
    gen_count = 0;
    growing = 1'b1;

    // Directed: empty-list cases, tail appends, bad positions, fill, then ops on a full list.
    queue_op(clri_pkg::FUNC_REMOVE, -1, 32'd0, 0);
    queue_op(clri_pkg::FUNC_ADVANCE, 0, 32'd0, 0);
    queue_op(FUNC_UNUSED, 0, 32'd5, 0);
    queue_op(clri_pkg::FUNC_ADD, -1, 32'h7FFF_FFFF, 0);
    queue_op(clri_pkg::FUNC_ADD, 0, 32'h8000_0000, 0);
    queue_op(clri_pkg::FUNC_ADD, 2, 32'd0, 0);
    queue_op(clri_pkg::FUNC_ADD, -2, 32'd11, 0);
    queue_op(clri_pkg::FUNC_ADD, 4, 32'd12, 0);
    queue_op(clri_pkg::FUNC_ADD, 31, 32'd13, 0);
    queue_op(clri_pkg::FUNC_ADD, -32, 32'd14, 0);
    queue_op(clri_pkg::FUNC_ADD, 1, 32'hFFFF_FFFF, 0);
    queue_op(clri_pkg::FUNC_ADVANCE, 0, 32'd0, 0);
    queue_op(clri_pkg::FUNC_REMOVE, 4, 32'd0, 0);
    queue_op(clri_pkg::FUNC_REMOVE, -2, 32'd0, 0);
    queue_op(clri_pkg::FUNC_REMOVE, 31, 32'd0, 0);
    queue_op(clri_pkg::FUNC_REMOVE, -1, 32'd0, 0);
    queue_op(clri_pkg::FUNC_REMOVE, 0, 32'd0, 0);
    queue_op(clri_pkg::FUNC_REMOVE, 1, 32'd0, 0);
    queue_op(FUNC_UNUSED, -1, 32'd0, 0);
    while (gen_count < int'(CAPACITY)) begin
      p = ($urandom_range(3) == 0) ? -1 : int'($urandom_range(gen_count, 0));
      queue_op(clri_pkg::FUNC_ADD, p, $urandom, 0);
    end
    queue_op(clri_pkg::FUNC_ADD, -1, 32'd1, 0);
    queue_op(clri_pkg::FUNC_ADD, 0, 32'd2, 0);
    queue_op(clri_pkg::FUNC_ADVANCE, 0, 32'd0, 0);
    queue_op(clri_pkg::FUNC_REMOVE, int'(CAPACITY) - 1, 32'd0, 0);

    for (int k = 0; k < RANDOM_OPS; k++) begin
      queue_random_op(k * 3 / RANDOM_OPS);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (queued_ops.size() != 0 || op_if.valid) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d transactions, %0d of them rejected; checked %0d results.",
             ops_accepted, ops_rejected, results_checked);
    $display("List stood full after %0d transactions; three idling patterns and one long stall.",
             full_seen);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/clri_pkg.sv
src/clri_in_if.sv
src/clri_out_if.sv
src/clri_cell.sv
src/circular_list_insert_remove_rotate_top.sv
tb/tb_top.sv
